// ===== rtl/drrc_pkg.sv =====
// Shared types, header offsets, field constants and checksum fold for the DHCP reply checker.
package drrc_pkg;

  localparam int HDRS_BYTES     = 28;   // IPv4 header plus UDP header
  localparam int DHCP_END_BYTES = 268;  // end of the magic cookie

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_CLIENT_PORT = 1'b0,
    REG_XID         = 1'b1
  } cfg_reg_t;

  // Offsets within the first 512 bytes of the datagram
  typedef logic [8:0] off_t;

  localparam off_t OFF_VER_IHL    = 9'd0;
  localparam off_t OFF_TOT_LEN_HI = 9'd2;
  localparam off_t OFF_TOT_LEN_LO = 9'd3;
  localparam off_t OFF_FRAG_HI    = 9'd6;
  localparam off_t OFF_FRAG_LO    = 9'd7;
  localparam off_t OFF_PROTO      = 9'd9;
  localparam off_t OFF_IP_CK_HI   = 9'd10;
  localparam off_t OFF_IP_CK_LO   = 9'd11;
  localparam off_t OFF_SRC_ADDR   = 9'd12;
  localparam off_t OFF_UDP        = 9'd20;
  localparam off_t OFF_SPORT_LO   = 9'd21;
  localparam off_t OFF_DPORT_HI   = 9'd22;
  localparam off_t OFF_DPORT_LO   = 9'd23;
  localparam off_t OFF_ULEN_HI    = 9'd24;
  localparam off_t OFF_ULEN_LO    = 9'd25;
  localparam off_t OFF_UCK_HI     = 9'd26;
  localparam off_t OFF_UCK_LO     = 9'd27;
  localparam off_t OFF_OP         = 9'd28;
  localparam off_t OFF_HTYPE      = 9'd29;
  localparam off_t OFF_HLEN       = 9'd30;
  localparam off_t OFF_XID_0      = 9'd32;
  localparam off_t OFF_XID_1      = 9'd33;
  localparam off_t OFF_XID_2      = 9'd34;
  localparam off_t OFF_XID_3      = 9'd35;
  localparam off_t OFF_COOKIE_0   = 9'd264;
  localparam off_t OFF_COOKIE_1   = 9'd265;
  localparam off_t OFF_COOKIE_2   = 9'd266;
  localparam off_t OFF_COOKIE_3   = 9'd267;

  localparam logic [7:0] VER_MASK     = 8'hf0;
  localparam logic [7:0] IHL_MASK     = 8'h0f;
  localparam logic [7:0] IPV4_VER     = 8'h40;
  localparam logic [7:0] IHL_NO_OPTS  = 8'h05;
  localparam logic [7:0] FRAG_HI_MASK = 8'h3f;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] BOOTREPLY    = 8'd2;
  localparam logic [7:0] HTYPE_ETHER  = 8'd1;
  localparam logic [7:0] HLEN_ETHER   = 8'd6;
  localparam logic [7:0] COOKIE_0     = 8'h63;
  localparam logic [7:0] COOKIE_1     = 8'h82;
  localparam logic [7:0] COOKIE_2     = 8'h53;
  localparam logic [7:0] COOKIE_3     = 8'h63;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT    = 3'd0,
    VERDICT_FILTERED  = 3'd1,
    VERDICT_TRUNCATED = 3'd2,
    VERDICT_BAD_IP    = 3'd3,
    VERDICT_BAD_UDP   = 3'd4
  } verdict_t;

  // Header captures and fixed-width sums of one datagram
  typedef struct packed {
    logic        filter_failed;
    logic [15:0] total_len;
    logic [15:0] udp_len;
    logic [15:0] udp_ck;
    logic [15:0] ip_ck;
    logic [15:0] udp_src;
    logic [15:0] udp_dst;
    logic [19:0] ip_sum;
    logic [19:0] pseudo_sum;
  } pkt_fields_t;

  // Ones' complement fold to 16 bits; three folds cover sums up to 48 bits
  function automatic logic [15:0] fold_complement(logic [47:0] s);
    logic [47:0] t;
    t = s;
    for (int i = 0; i < 3; i++) begin
      t = {32'd0, t[15:0]} + {16'd0, t[47:16]};
    end
    return ~t[15:0];
  endfunction

endpackage

// ===== rtl/drrc_accum.sv =====
// Per-byte header capture, filter tests and running checksums of one datagram.
module drrc_accum import drrc_pkg::*; #(
  parameter int MAX_PACKET_BYTES = 2048,
  localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1),
  localparam int SUM_W = 17 + $clog2(MAX_PACKET_BYTES)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,            // byte taken this cycle
  input  logic [7:0]        data,
  input  logic              last,
  input  logic [15:0]       client_port,
  input  logic [31:0]       xid,
  output pkt_fields_t       snap,          // state including this byte
  output logic [CNT_W-1:0]  snap_len,
  output logic [SUM_W-1:0]  snap_udp_sum
);

  pkt_fields_t       fields, fields_next;
  logic [CNT_W-1:0]  byte_count, byte_count_next;
  logic [SUM_W-1:0]  udp_sum, udp_sum_next;

  logic              in_range;
  logic              head;
  off_t              off;
  logic [15:0]       w;
  logic [16:0]       off_ext;
  logic [16:0]       udp_end;
  logic              ok;

  always_comb begin
    fields_next     = fields;
    byte_count_next = byte_count;
    udp_sum_next    = udp_sum;
    ok              = 1'b1;

    in_range = byte_count < CNT_W'(MAX_PACKET_BYTES);
    head     = (byte_count >> 9) == '0;
    off      = byte_count[8:0];
    off_ext  = 17'(byte_count);
    w        = byte_count[0] ? {8'd0, data} : {data, 8'd0};
    udp_end  = 17'(OFF_UDP) + {1'b0, fields.udp_len};

    if (in_range) begin
      byte_count_next = byte_count + 1'b1;

      if (off_ext >= 17'(HDRS_BYTES) && off_ext < udp_end) begin
        udp_sum_next = udp_sum + SUM_W'(w);
      end

      if (head) begin
        if (off < OFF_UDP && off != OFF_IP_CK_HI && off != OFF_IP_CK_LO) begin
          fields_next.ip_sum = fields.ip_sum + 20'(w);
        end
        if (off == OFF_PROTO || (off >= OFF_SRC_ADDR && off < OFF_UDP)) begin
          fields_next.pseudo_sum = fields.pseudo_sum + 20'(w);
        end

        case (off)
          OFF_VER_IHL: begin
            ok = ((data & VER_MASK) == IPV4_VER) && ((data & IHL_MASK) == IHL_NO_OPTS);
          end
          OFF_TOT_LEN_HI, OFF_TOT_LEN_LO: begin
            fields_next.total_len = {fields.total_len[7:0], data};
          end
          OFF_FRAG_HI: ok = (data & FRAG_HI_MASK) == 8'd0;
          OFF_FRAG_LO: ok = data == 8'd0;
          OFF_PROTO:   ok = data == PROTO_UDP;
          OFF_IP_CK_HI, OFF_IP_CK_LO: begin
            fields_next.ip_ck = {fields.ip_ck[7:0], data};
          end
          OFF_UDP, OFF_SPORT_LO: begin
            fields_next.udp_src = {fields.udp_src[7:0], data};
          end
          OFF_DPORT_HI: begin
            fields_next.udp_dst = {fields.udp_dst[7:0], data};
            ok = data == client_port[15:8];
          end
          OFF_DPORT_LO: begin
            fields_next.udp_dst = {fields.udp_dst[7:0], data};
            ok = data == client_port[7:0];
          end
          OFF_ULEN_HI, OFF_ULEN_LO: begin
            fields_next.udp_len = {fields.udp_len[7:0], data};
          end
          OFF_UCK_HI, OFF_UCK_LO: begin
            fields_next.udp_ck = {fields.udp_ck[7:0], data};
          end
          OFF_OP:       ok = data == BOOTREPLY;
          OFF_HTYPE:    ok = data == HTYPE_ETHER;
          OFF_HLEN:     ok = data == HLEN_ETHER;
          OFF_XID_0:    ok = data == xid[31:24];
          OFF_XID_1:    ok = data == xid[23:16];
          OFF_XID_2:    ok = data == xid[15:8];
          OFF_XID_3:    ok = data == xid[7:0];
          OFF_COOKIE_0: ok = data == COOKIE_0;
          OFF_COOKIE_1: ok = data == COOKIE_1;
          OFF_COOKIE_2: ok = data == COOKIE_2;
          OFF_COOKIE_3: ok = data == COOKIE_3;
          default: ;
        endcase
      end
    end

    fields_next.filter_failed = fields.filter_failed | ~ok;
  end

  assign snap         = fields_next;
  assign snap_len     = byte_count_next;
  assign snap_udp_sum = udp_sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      fields     <= '0;
      byte_count <= '0;
      udp_sum    <= '0;
    end else if (go) begin
      if (last) begin
        // clear for the next datagram
        fields     <= '0;
        byte_count <= '0;
        udp_sum    <= '0;
      end else begin
        fields     <= fields_next;
        byte_count <= byte_count_next;
        udp_sum    <= udp_sum_next;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (go && last) |=> (byte_count == '0 && !fields.filter_failed && udp_sum == '0))
    else $error("accumulator not cleared after final byte");

  a_count_capped: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_W'(MAX_PACKET_BYTES))
    else $error("byte count beyond maximum");

  a_count_advance: assert property (@(posedge clk) disable iff (rst)
    (go && !last && byte_count < CNT_W'(MAX_PACKET_BYTES)) |=>
      byte_count == $past(byte_count) + 1'b1)
    else $error("byte count did not advance");

endmodule

// ===== rtl/drrc_judge.sv =====
// Length, filter and IP checksum tests, and the UDP checksum sum of a finished datagram.
module drrc_judge import drrc_pkg::*; #(
  parameter int MAX_PACKET_BYTES = 2048,
  parameter int MIN_PACKET_BYTES = 268,
  localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1),
  localparam int SUM_W = 17 + $clog2(MAX_PACKET_BYTES),
  localparam int S_W   = SUM_W + 3
) (
  input  pkt_fields_t       fields,
  input  logic [CNT_W-1:0]  len,
  input  logic [SUM_W-1:0]  udp_sum,
  output verdict_t          code,       // verdict before the UDP checksum test
  output logic              udp_test,   // UDP checksum still to be compared
  output logic [S_W-1:0]    udp_total
);

  logic [16:0] len_ext;
  logic [16:0] udp_end;
  logic        filtered;
  logic        truncated;
  logic        ip_bad;
  logic [15:0] w_src, w_dst, w_len;

  assign len_ext = 17'(len);
  assign udp_end = 17'(OFF_UDP) + {1'b0, fields.udp_len};

  assign filtered = fields.filter_failed ||
                    len_ext < 17'(MIN_PACKET_BYTES) ||
                    len_ext < 17'(DHCP_END_BYTES);
  assign truncated = len_ext < {1'b0, fields.total_len} || len_ext < udp_end;
  assign ip_bad    = fold_complement(48'(fields.ip_sum)) != fields.ip_ck;

  // UDP header words count only where they lie inside the UDP length; pad a split word
  always_comb begin
    w_src = 16'd0;
    w_dst = 16'd0;
    w_len = 16'd0;
    if (udp_end >= 17'(OFF_DPORT_HI)) begin
      w_src = fields.udp_src;
    end else if (udp_end > 17'(OFF_UDP)) begin
      w_src = fields.udp_src & 16'hff00;
    end
    if (udp_end >= 17'(OFF_ULEN_HI)) begin
      w_dst = fields.udp_dst;
    end else if (udp_end > 17'(OFF_DPORT_HI)) begin
      w_dst = fields.udp_dst & 16'hff00;
    end
    if (udp_end >= 17'(OFF_UCK_HI)) begin
      w_len = fields.udp_len;
    end else if (udp_end > 17'(OFF_ULEN_HI)) begin
      w_len = fields.udp_len & 16'hff00;
    end
  end

  assign udp_total = S_W'(fields.pseudo_sum) + S_W'(fields.udp_len) + S_W'(udp_sum) +
                     S_W'(w_src) + S_W'(w_dst) + S_W'(w_len);

  always_comb begin
    if (filtered) begin
      code = VERDICT_FILTERED;
    end else if (truncated) begin
      code = VERDICT_TRUNCATED;
    end else if (ip_bad) begin
      code = VERDICT_BAD_IP;
    end else begin
      code = VERDICT_ACCEPT;
    end
  end

  assign udp_test = fields.udp_ck != 16'd0;

endmodule

// ===== rtl/dhcp_reply_receive_checker.sv =====
// Top level of the DHCP reply receive checker: stream ports, config registers, verdict pipeline.
// Takes an IPv4 datagram one byte per beat, starting at the IP header, and gives one result
// beat per datagram, after the beat marked last: a verdict (accepted, filtered out,
// truncated, bad IP checksum, bad UDP checksum, in that order of precedence) and, for
// accepted datagrams, the DHCP payload length (bytes received minus 28, else 0). Bytes
// past MAX_PACKET_BYTES are dropped from the count and the sums. Throughput is one byte
// per clock, set by the running checksum adders that take each byte as it arrives; the
// final byte and its result beat pass the input register, snapshot register, check
// register and result register in turn. Input beats keep flowing while a result waits;
// only a further final byte stalls once all verdict stages are full.
// Write client_port and transaction_id only between datagrams.
module dhcp_reply_receive_checker import drrc_pkg::*; #(
  parameter int MAX_PACKET_BYTES = 2048,
  parameter int MIN_PACKET_BYTES = 268
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [2:0] verdict, [13:3] payload_length, [15:14] zero

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int SUM_W = 17 + $clog2(MAX_PACKET_BYTES);
  localparam int S_W   = SUM_W + 3;

  // Configuration
  logic [15:0] client_port;
  logic [31:0] transaction_id;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      client_port    <= 16'd68;
      transaction_id <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_CLIENT_PORT: client_port    <= cfg_data[15:0];
        REG_XID:         transaction_id <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline registers
  logic              a_valid;
  logic [7:0]        a_data;
  logic              a_last;

  logic              b_valid;
  pkt_fields_t       b_fields;
  logic [CNT_W-1:0]  b_len;
  logic [SUM_W-1:0]  b_udp_sum;

  logic              c_valid;
  verdict_t          c_code;
  logic              c_udp_test;
  logic [15:0]       c_udp_ck;
  logic [S_W-1:0]    c_udp_total;
  logic [CNT_W-1:0]  c_len;

  verdict_t          verdict;
  logic [10:0]       payload_length;

  logic              o_free, c_free, b_free, a_go;

  assign o_free        = !m_axis_tvalid || m_axis_tready;
  assign c_free        = !c_valid || o_free;
  assign b_free        = !b_valid || c_free;
  // a non-final byte only updates the sums; a final byte needs a free snapshot slot
  assign a_go          = a_valid && (!a_last || b_free);
  assign s_axis_tready = !a_valid || a_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_axis_tready) begin
      a_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      a_data <= s_axis_tdata;
      a_last <= s_axis_tlast;
    end
  end

  // Byte accumulation
  pkt_fields_t       snap;
  logic [CNT_W-1:0]  snap_len;
  logic [SUM_W-1:0]  snap_udp_sum;

  drrc_accum #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .go           (a_go),
    .data         (a_data),
    .last         (a_last),
    .client_port  (client_port),
    .xid          (transaction_id),
    .snap         (snap),
    .snap_len     (snap_len),
    .snap_udp_sum (snap_udp_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_go && a_last;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free) begin
      b_fields  <= snap;
      b_len     <= snap_len;
      b_udp_sum <= snap_udp_sum;
    end
  end

  // Length, filter and IP checksum tests
  verdict_t       j_code;
  logic           j_udp_test;
  logic [S_W-1:0] j_udp_total;

  drrc_judge #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES),
    .MIN_PACKET_BYTES(MIN_PACKET_BYTES)
  ) u_judge (
    .fields    (b_fields),
    .len       (b_len),
    .udp_sum   (b_udp_sum),
    .code      (j_code),
    .udp_test  (j_udp_test),
    .udp_total (j_udp_total)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_free) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_free) begin
      c_code      <= j_code;
      c_udp_test  <= j_udp_test;
      c_udp_ck    <= b_fields.udp_ck;
      c_udp_total <= j_udp_total;
      c_len       <= b_len;
    end
  end

  // UDP checksum fold and final verdict
  logic        udp_bad;
  verdict_t    final_verdict;
  logic [10:0] final_payload;

  assign udp_bad = c_udp_test && (fold_complement(48'(c_udp_total)) != c_udp_ck);

  always_comb begin
    if (c_code != VERDICT_ACCEPT) begin
      final_verdict = c_code;
    end else if (udp_bad) begin
      final_verdict = VERDICT_BAD_UDP;
    end else begin
      final_verdict = VERDICT_ACCEPT;
    end
    final_payload = (final_verdict == VERDICT_ACCEPT) ?
                    11'(c_len - CNT_W'(HDRS_BYTES)) : 11'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (o_free) begin
      m_axis_tvalid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_free) begin
      verdict        <= final_verdict;
      payload_length <= final_payload;
    end
  end

  assign m_axis_tdata = {2'b00, payload_length, verdict};

  a_payload_only_accepted: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && verdict != VERDICT_ACCEPT) |-> payload_length == 11'd0)
    else $error("payload length on a rejected datagram");

  a_last_waits: assert property (@(posedge clk) disable iff (rst)
    (a_valid && a_last && !b_free) |=> (a_valid && a_last && $stable(a_data)))
    else $error("final byte dropped while verdict stages full");

  a_snapshot_holds: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !c_free) |=> (b_valid && $stable(b_len) && $stable(b_fields)))
    else $error("snapshot overwritten while check stage stalled");

  a_final_to_snapshot: assert property (@(posedge clk) disable iff (rst)
    (a_go && a_last) |=> b_valid)
    else $error("final byte did not reach snapshot stage");

endmodule
